@@ design/smpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package smpq_pkg;

    localparam int DEPTH = 16;
    localparam int VAL_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OUT_CNT_W = 5;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_REMOVE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-cell control from the top level
    typedef struct packed {
        logic en;       // operation is carried out this cycle
        logic ins;      // 1 insert, 0 remove
        logic occ;      // cell holds a stored value
        logic at_end;   // cell is the first free slot
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ design/sorted_max_priority_queue_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// sorted max priority queue, a row of DEPTH cells kept in descending order
//
// input channel (s_axis): tuser carries the operation (0 insert, 1 remove
// maximum), tdata the signed 32-bit value, ignored on remove
// output channel (m_axis): one word per input word with the status, the
// removed value, the new head, a head-valid flag and the count
//
// each cell compares the incoming value with its own entry and passes its
// verdict to the next cell, so an insert or remove updates the whole row at
// once; a word is taken every cycle while the receiver keeps up, and its
// result is shown in the next cycle in the output register
//
// a rejected insert (full) or remove (empty) leaves the store unchanged
// reset empties the queue and drops any waiting result, and tready stays
// low while reset is held; the stored values need no clearing since only
// entries below the count are ever read
// when the receiver stalls, the result holds and tready falls until it is
// taken
module sorted_max_priority_queue_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,   // value[31:0]
    input  wire  [0:0]  i_s_axis_tuser,   // func[0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // status[1:0], removed_value[33:2], head_value[65:34], head_valid[66],
    // count[71:67]
    output logic [71:0] o_m_axis_tdata
);
    import smpq_pkg::*;

    t_cnt r_cnt;
    t_cnt n_cnt;
    logic r_out_valid;

    t_status r_status;
    t_status n_status;
    t_val    r_removed;
    t_val    n_removed;
    t_val    r_head;
    t_val    n_head;
    logic    r_head_vld;

    logic    w_acc;
    logic    w_ins;
    logic    w_full;
    logic    w_empty;
    logic    w_do;
    t_val    w_value;

    t_val      w_val [DEPTH+1];
    logic      w_gt  [DEPTH+1];
    t_val      w_nxt [DEPTH];
    t_cell_ctl w_ctl [DEPTH];

    assign o_s_axis_tready = i_rst_n && (!r_out_valid || i_m_axis_tready);
    assign w_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ins   = (t_func'(i_s_axis_tuser[0]) == FN_INSERT);
    assign w_value = i_s_axis_tdata;
    assign w_full  = (r_cnt >= CNT_W'(DEPTH));
    assign w_empty = (r_cnt == '0);
    assign w_do    = w_acc && (w_ins ? !w_full : !w_empty);

    // chain ends: nothing shifts in from before the head or after the tail
    assign w_gt[0]      = 1'b0;
    assign w_val[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_val w_left;
        assign w_left = (g == 0) ? t_val'(0) : w_val[(g == 0) ? 0 : g-1];

        assign w_ctl[g].en     = w_do;
        assign w_ctl[g].ins    = w_ins;
        assign w_ctl[g].occ    = (CNT_W'(g) < r_cnt);
        assign w_ctl[g].at_end = (CNT_W'(g) == r_cnt);

        smpq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[g]),
            .i_value     (w_value),
            .i_left_val  (w_left),
            .i_left_gt   (w_gt[g]),
            .i_right_val (w_val[g+1]),
            .o_val       (w_val[g]),
            .o_gt        (w_gt[g+1]),
            .o_nxt       (w_nxt[g])
        );
    end

    always_comb begin
        n_cnt     = r_cnt;
        n_status  = ST_DONE;
        n_removed = '0;
        if (w_ins) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_cnt = r_cnt + t_cnt'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_cnt     = r_cnt - t_cnt'(1);
                n_removed = w_val[0];
            end
        end
        n_head = (n_cnt != '0) ? w_nxt[0] : t_val'(0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_cnt <= n_cnt;
            end
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status   <= n_status;
            r_removed  <= n_removed;
            r_head     <= n_head;
            r_head_vld <= (n_cnt != '0);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {OUT_CNT_W'(r_cnt), r_head_vld, r_head, r_removed, r_status};

    // count never exceeds the store
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("count above depth");

    // successful insert grows the count by one
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_ins && !w_full) |=> (r_cnt == $past(r_cnt) + t_cnt'(1)))
        else $error("insert did not grow count");

    // rejected operations leave the count alone
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && ((w_ins && w_full) || (!w_ins && w_empty))) |=> $stable(r_cnt))
        else $error("rejected word changed count");

    // every accepted word leaves a result
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_out_valid)
        else $error("accepted word produced no result");

    // head flag agrees with the reported count
    a_head_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_head_vld == (r_cnt != '0)))
        else $error("head flag disagrees with count");

endmodule
`default_nettype wire

@@ design/smpq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module smpq_cell (
    input  wire                     i_clk,
    input  smpq_pkg::t_cell_ctl     i_ctl,
    input  smpq_pkg::t_val          i_value,
    input  smpq_pkg::t_val          i_left_val,
    input  wire                     i_left_gt,
    input  smpq_pkg::t_val          i_right_val,
    output smpq_pkg::t_val          o_val,
    output logic                    o_gt,
    output smpq_pkg::t_val          o_nxt
);
    import smpq_pkg::*;

    t_val r_val;
    t_val n_val;

    // new value goes behind every stored value that is >= it
    assign o_gt = i_ctl.occ ? (i_value > r_val) : i_ctl.at_end;

    always_comb begin
        if (!i_ctl.en) begin
            n_val = r_val;
        end else if (i_ctl.ins) begin
            if (i_left_gt) begin
                n_val = i_left_val;
            end else if (o_gt) begin
                n_val = i_value;
            end else begin
                n_val = r_val;
            end
        end else begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_nxt = n_val;

endmodule
`default_nettype wire

@@ test/sorted_max_priority_queue_unit_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for the sorted max priority queue
module sorted_max_priority_queue_unit_tb;
    import smpq_pkg::*;

    localparam int RAND_WORDS  = 1650;     // random words after the directed table
    localparam int CYCLE_LIMIT = 200000;   // hard stop, far above the slowest legal run
    localparam int DRAIN_WAIT  = 4;        // settle time after the last result is taken
    localparam int N_ROWS      = 13;

    localparam t_val VAL_MAX = 32'sh7fffffff;
    localparam t_val VAL_MIN = 32'sh80000000;

    // one output word, laid out as the m_axis tdata bus (msb first)
    typedef struct packed {
        logic [OUT_CNT_W-1:0] count;
        logic                 head_valid;
        t_val                 head;
        t_val                 removed;
        t_status              status;
    } t_result;

    // directed stimulus row; want is only used when typed is set
    typedef struct packed {
        t_func   fn;
        t_val    value;
        int      reps;
        bit      typed;
        t_result want;
    } t_row;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SLOW,
        RX_PERIODIC
    } t_rx_mode;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    // side info that travels with the word on the input bus
    bit          cur_typed = 1'b0;
    t_result     cur_want  = '0;

    // predictor state: sorted copy of the store and its occupancy
    t_val        model_vals [DEPTH];
    int          model_cnt = 0;

    t_result     pending_results [$];

    int          mismatch_cnt = 0;
    int          cycle_cnt    = 0;
    int          words_sent   = 0;
    int          burst_left   = 0;
    int          n_done = 0, n_full = 0, n_empty = 0, peak_cnt = 0;
    t_rx_mode    rx_mode  = RX_OPEN;
    int          rx_left  = 0;

    // directed table: reset, extremes, empty and full rejects, equal values
    // want fields in order: count, head_valid, head, removed, status
    t_row dir_rows [0:N_ROWS-1] = '{
        // remove right after reset
        '{FN_REMOVE, 32'sd0, 1, 1'b1, '{5'd0, 1'b0, 32'sd0, 32'sd0, ST_EMPTY}},
        // largest and smallest values
        '{FN_INSERT, VAL_MAX, 1, 1'b1, '{5'd1, 1'b1, VAL_MAX, 32'sd0, ST_DONE}},
        '{FN_INSERT, VAL_MIN, 1, 1'b1, '{5'd2, 1'b1, VAL_MAX, 32'sd0, ST_DONE}},
        '{FN_REMOVE, 32'sd0, 1, 1'b1, '{5'd1, 1'b1, VAL_MIN, VAL_MAX, ST_DONE}},
        '{FN_REMOVE, -32'sd1, 1, 1'b1, '{5'd0, 1'b0, 32'sd0, VAL_MIN, ST_DONE}},
        // empty again, value field all ones must be ignored
        '{FN_REMOVE, -32'sd1, 1, 1'b1, '{5'd0, 1'b0, 32'sd0, 32'sd0, ST_EMPTY}},
        // equal values and small mixed signs
        '{FN_INSERT, 32'sd5, 2, 1'b0, '0},
        '{FN_INSERT, -32'sd1, 1, 1'b0, '0},
        '{FN_INSERT, 32'sd0, 1, 1'b0, '0},
        // fill to the last slot
        '{FN_INSERT, 32'sd7, 5, 1'b0, '0},
        '{FN_INSERT, -32'sd7, 4, 1'b0, '0},
        '{FN_INSERT, VAL_MAX, 3, 1'b0, '0},
        // insert into a full store, head stays at the max
        '{FN_INSERT, 32'sd1, 1, 1'b1, '{5'd16, 1'b1, VAL_MAX, 32'sd0, ST_FULL}}
    };

    sorted_max_priority_queue_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // value[31:0]
        .i_s_axis_tuser  (s_tuser),    // func[0]
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        // status[1:0], removed_value[33:2], head_value[65:34], head_valid[66],
        // count[71:67]
        .o_m_axis_tdata  (m_tdata)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predicted result of one operation, updates the model store
    function automatic t_result predict_queue_op(input t_func fn, input t_val v);
        t_result r;
        int      pos;
        int      k;
        r = '0;
        r.status = ST_DONE;
        if (fn == FN_INSERT) begin
            if (model_cnt >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // walk toward the head past every strictly smaller entry
                pos = model_cnt;
                while (pos > 0 && v > model_vals[pos-1]) begin
                    model_vals[pos] = model_vals[pos-1];
                    pos--;
                end
                model_vals[pos] = v;
                model_cnt++;
            end
        end else begin
            if (model_cnt == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.removed = model_vals[0];
                for (k = 0; k + 1 < model_cnt; k++)
                    model_vals[k] = model_vals[k+1];
                model_cnt--;
            end
        end
        r.head       = (model_cnt > 0) ? model_vals[0] : '0;
        r.head_valid = (model_cnt > 0);
        r.count      = model_cnt[OUT_CNT_W-1:0];
        return r;
    endfunction

    // present one word, hold it until taken, then maybe open a gap
    task automatic send_word(input t_func fn, input t_val v, input bit typed,
                             input t_result want);
        int gap;
        s_tvalid  <= 1'b1;
        s_tdata   <= v;
        s_tuser   <= fn;
        cur_typed <= typed;
        cur_want  <= want;
        do @(posedge i_clk); while (!s_tready);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // end of burst: new length, and a gap that may be zero
            burst_left = $urandom_range(40, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // random value mix: wide, tiny (many equal values), and the extremes
    function automatic t_val pick_value();
        t_val v;
        case ($urandom_range(3))
            0: v = $urandom_range(8) - 4;
            1: begin
                case ($urandom_range(3))
                    0: v = VAL_MAX;
                    1: v = VAL_MIN;
                    2: v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // receiver: picks a new stall pattern whenever its random run length runs out
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(3));
            rx_left = $urandom_range(200, 20);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(1));
            RX_SLOW:     m_tready <= ($urandom_range(3) == 0);
            default:     m_tready <= cycle_cnt[2];
        endcase
    end

    // both handshakes at one edge: the result leaving belongs to an older word,
    // so it is checked before the new word is predicted
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result pred;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got = t_result'(m_tdata);
                if (pending_results.size() == 0) begin
                    $error("unexpected output word %h", m_tdata);
                    mismatch_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        mismatch_cnt++;
                    end
                    if (got.removed !== want.removed) begin
                        $error("removed_value: expected %0d, actual %0d",
                               want.removed, got.removed);
                        mismatch_cnt++;
                    end
                    if (got.head !== want.head) begin
                        $error("head_value: expected %0d, actual %0d", want.head, got.head);
                        mismatch_cnt++;
                    end
                    if (got.head_valid !== want.head_valid) begin
                        $error("head_valid: expected %0d, actual %0d",
                               want.head_valid, got.head_valid);
                        mismatch_cnt++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, got.count);
                        mismatch_cnt++;
                    end
                end
                case (got.status)
                    ST_FULL:  n_full++;
                    ST_EMPTY: n_empty++;
                    default:  n_done++;
                endcase
                if (int'(got.count) > peak_cnt)
                    peak_cnt = int'(got.count);
            end
            if (s_tvalid && s_tready) begin
                // predictor always runs so its store stays in step
                pred = predict_queue_op(t_func'(s_tuser), t_val'(s_tdata));
                pending_results.push_back(cur_typed ? cur_want : pred);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words waiting",
                     cycle_cnt, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus
    initial begin
        int rnd_sent;
        int ins_pct;
        int run_len;
        t_func fn;
        for (int i = 0; i < DEPTH; i++)
            model_vals[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[r]) begin
            repeat (dir_rows[r].reps)
                send_word(dir_rows[r].fn, dir_rows[r].value, dir_rows[r].typed,
                          dir_rows[r].want);
        end

        // random phases with an insert bias: drain hard, balanced, fill hard
        rnd_sent = 0;
        while (rnd_sent < RAND_WORDS) begin
            case ($urandom_range(2))
                0:       ins_pct = 15;
                1:       ins_pct = 50;
                default: ins_pct = 85;
            endcase
            run_len = $urandom_range(80, 20);
            for (int j = 0; j < run_len && rnd_sent < RAND_WORDS; j++) begin
                fn = ($urandom_range(99) < ins_pct) ? FN_INSERT : FN_REMOVE;
                send_word(fn, (fn == FN_INSERT) ? pick_value() : t_val'($urandom),
                          1'b0, '0);
                rnd_sent++;
            end
        end
        s_tvalid <= 1'b0;

        // drain, then let the output register settle before the summary
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d words in %0d cycles, peak count %0d of %0d",
                 words_sent, cycle_cnt, peak_cnt, DEPTH);
        $display("results: %0d done, %0d rejected full, %0d rejected empty",
                 n_done, n_full, n_empty);
        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
